// ----- hdl/current_occupancy_detector_macros.svh -----
// Assertion macros shared by the occupancy detector sources.
// Each check is sampled on the rising edge of aclk and is held off while reset is asserted.
`ifndef CURRENT_OCCUPANCY_DETECTOR_MACROS_SVH
`define CURRENT_OCCUPANCY_DETECTOR_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication.
`define COD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("occupancy detector check failed");
// Next-cycle implication.
`define COD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("occupancy detector check failed");
`else
`define COD_ASSERT_NOW(lbl, ante, cons)
`define COD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- hdl/cod_pkg.sv -----
package cod_pkg;

    localparam int NUM_CH       = 4;
    localparam int SAMPLE_W     = 10;
    localparam int THR_W        = 11;
    localparam int DELAY_W      = 8;
    localparam int EXT_W        = 8;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 32;

    // Hysteresis applied to the threshold and its limits.
    localparam logic [SAMPLE_W-1:0] HYST     = 10'd5;
    localparam logic [SAMPLE_W-1:0] HYST_TOP = 10'd1018;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_THR_CH0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_CH1    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_CH2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_CH3    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ON_DELAYS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_DELAYS = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [THR_W-1:0]      THR_RESET       = 11'd1024;
    localparam logic [CFG_DATA_W-1:0] ON_DELAYS_RESET  = 32'h0404_0404;
    localparam logic [CFG_DATA_W-1:0] OFF_DELAYS_RESET = 32'h1919_1919;

    // Per-channel settings handed to each channel unit.
    typedef struct packed {
        logic [THR_W-1:0]   threshold;
        logic [DELAY_W-1:0] on_delay;
        logic [DELAY_W-1:0] off_delay;
    } chan_cfg_t;

endpackage

// ----- hdl/cod_channel.sv -----
module cod_channel (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           step,
    input  logic [cod_pkg::SAMPLE_W-1:0]   sample,
    input  logic [cod_pkg::SAMPLE_W-1:0]   reference,
    input  cod_pkg::chan_cfg_t             cfg,
    output logic                           occupied_next
);
    import cod_pkg::*;

    logic                occupied_reg;
    logic [DELAY_W-1:0]  on_cnt_reg;
    logic [DELAY_W-1:0]  off_cnt_reg;
    logic [DELAY_W-1:0]  on_cnt_next;
    logic [DELAY_W-1:0]  off_cnt_next;
    logic [SAMPLE_W-1:0] base_thr;
    logic [SAMPLE_W-1:0] thr;
    logic                above;

    // Threshold selection and hysteresis.
    always_comb begin
        base_thr = cfg.threshold[THR_W-1] ? reference : cfg.threshold[SAMPLE_W-1:0];
        thr      = base_thr;
        if (occupied_reg && (base_thr >= HYST)) begin
            thr = base_thr - HYST;
        end else if (!occupied_reg && (base_thr <= HYST_TOP)) begin
            thr = base_thr + HYST;
        end
        above = sample > thr;
    end

    // Turn-on and turn-off delay counting.
    always_comb begin
        occupied_next = occupied_reg;
        on_cnt_next   = on_cnt_reg;
        off_cnt_next  = off_cnt_reg;
        if (above) begin
            if (!occupied_reg) begin
                if (on_cnt_reg < cfg.on_delay) begin
                    on_cnt_next = on_cnt_reg + 8'd1;
                end else begin
                    occupied_next = 1'b1;
                    off_cnt_next  = '0;
                end
            end else begin
                off_cnt_next = '0;
            end
        end else begin
            if (occupied_reg) begin
                if (off_cnt_reg < cfg.off_delay) begin
                    off_cnt_next = off_cnt_reg + 8'd1;
                end else begin
                    occupied_next = 1'b0;
                    on_cnt_next   = '0;
                end
            end else begin
                on_cnt_next = '0;
            end
        end
    end

    // Channel state advances once per item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occupied_reg <= 1'b0;
            on_cnt_reg   <= '0;
            off_cnt_reg  <= '0;
        end else if (step) begin
            occupied_reg <= occupied_next;
            on_cnt_reg   <= on_cnt_next;
            off_cnt_reg  <= off_cnt_next;
        end
    end

endmodule

// ----- hdl/cod_debounce.sv -----
module cod_debounce (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step,
    input  logic [cod_pkg::EXT_W-1:0]   raw,
    output logic [cod_pkg::EXT_W-1:0]   debounced_next
);
    import cod_pkg::*;

    logic [EXT_W-1:0] low_reg;
    logic [EXT_W-1:0] high_reg;
    logic [EXT_W-1:0] debounced_reg;
    logic [EXT_W-1:0] low_next;
    logic [EXT_W-1:0] high_next;
    logic [EXT_W-1:0] delta;

    // Two-bit vertical counter: each differing bit counts, and flips on wrap to zero.
    always_comb begin
        delta          = raw ^ debounced_reg;
        high_next      = (high_reg ^ low_reg) & delta;
        low_next       = ~low_reg & delta;
        debounced_next = debounced_reg ^ (delta & ~(high_next | low_next));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg       <= '0;
            high_reg      <= '0;
            debounced_reg <= '0;
        end else if (step) begin
            low_reg       <= low_next;
            high_reg      <= high_next;
            debounced_reg <= debounced_next;
        end
    end

endmodule

// ----- hdl/current_occupancy_detector.sv -----
// An accepted item waits in the input register and moves on to the result register when
// that register is free or being drained. Throughput: one item per cycle while m_ready
// holds; the channel and debounce logic between the two registers is combinational.
// Reset: aresetn is synchronous and active low; it clears all channel and debounce
// state, empties both registers and restores the configuration reset values.
module current_occupancy_detector (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [cod_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cod_pkg::CFG_DATA_W-1:0]   cfg_data,
    // Scan input channel
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [cod_pkg::SAMPLE_W-1:0]     s_current_ch0,
    input  logic [cod_pkg::SAMPLE_W-1:0]     s_current_ch1,
    input  logic [cod_pkg::SAMPLE_W-1:0]     s_current_ch2,
    input  logic [cod_pkg::SAMPLE_W-1:0]     s_current_ch3,
    input  logic [cod_pkg::SAMPLE_W-1:0]     s_reference_ch0,
    input  logic [cod_pkg::SAMPLE_W-1:0]     s_reference_ch1,
    input  logic [cod_pkg::SAMPLE_W-1:0]     s_reference_ch2,
    input  logic [cod_pkg::SAMPLE_W-1:0]     s_reference_ch3,
    input  logic [cod_pkg::EXT_W-1:0]        s_external_raw,
    // Result channel
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [cod_pkg::NUM_CH-1:0]       m_current_status,
    output logic [cod_pkg::EXT_W-1:0]        m_external_status,
    output logic                             m_status_changed
);
    import cod_pkg::*;

    // Configuration registers
    logic [THR_W-1:0]      thr_reg [NUM_CH];
    logic [CFG_DATA_W-1:0] on_delays_reg;
    logic [CFG_DATA_W-1:0] off_delays_reg;

    // Input register
    logic                in_valid_reg;
    logic [SAMPLE_W-1:0] cur_reg [NUM_CH];
    logic [SAMPLE_W-1:0] ref_reg [NUM_CH];
    logic [EXT_W-1:0]    raw_reg;

    // Result register and change tracking
    logic                m_valid_reg;
    logic [NUM_CH-1:0]   m_cur_status_reg;
    logic [EXT_W-1:0]    m_ext_status_reg;
    logic                m_changed_reg;
    logic [NUM_CH-1:0]   prev_occ_reg;
    logic [EXT_W-1:0]    prev_db_reg;

    logic                advance;
    logic                changed;
    logic [NUM_CH-1:0]   occ_next;
    logic [EXT_W-1:0]    db_next;
    chan_cfg_t           chan_cfg [NUM_CH];

    assign cfg_ready = 1'b1;

    // An item moves to the result register when that register is free or being drained.
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CH; i++) begin
                thr_reg[i] <= THR_RESET;
            end
            on_delays_reg  <= ON_DELAYS_RESET;
            off_delays_reg <= OFF_DELAYS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_THR_CH0:    thr_reg[0]     <= cfg_data[THR_W-1:0];
                CFG_THR_CH1:    thr_reg[1]     <= cfg_data[THR_W-1:0];
                CFG_THR_CH2:    thr_reg[2]     <= cfg_data[THR_W-1:0];
                CFG_THR_CH3:    thr_reg[3]     <= cfg_data[THR_W-1:0];
                CFG_ON_DELAYS:  on_delays_reg  <= cfg_data;
                CFG_OFF_DELAYS: off_delays_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Input register: valid flag under reset, payload without.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cur_reg[0] <= s_current_ch0;
            cur_reg[1] <= s_current_ch1;
            cur_reg[2] <= s_current_ch2;
            cur_reg[3] <= s_current_ch3;
            ref_reg[0] <= s_reference_ch0;
            ref_reg[1] <= s_reference_ch1;
            ref_reg[2] <= s_reference_ch2;
            ref_reg[3] <= s_reference_ch3;
            raw_reg    <= s_external_raw;
        end
    end

    // One unit per current channel.
    for (genvar g = 0; g < NUM_CH; g++) begin : g_chan
        assign chan_cfg[g].threshold = thr_reg[g];
        assign chan_cfg[g].on_delay  = on_delays_reg[DELAY_W*g +: DELAY_W];
        assign chan_cfg[g].off_delay = off_delays_reg[DELAY_W*g +: DELAY_W];

        cod_channel u_channel (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .step          (advance),
            .sample        (cur_reg[g]),
            .reference     (ref_reg[g]),
            .cfg           (chan_cfg[g]),
            .occupied_next (occ_next[g])
        );
    end

    cod_debounce u_debounce (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (advance),
        .raw            (raw_reg),
        .debounced_next (db_next)
    );

    assign changed = (occ_next != prev_occ_reg) || (db_next != prev_db_reg);

    // Result register and the statuses last reported.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            prev_occ_reg <= '0;
            prev_db_reg  <= '0;
        end else begin
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (advance && changed) begin
                prev_occ_reg <= occ_next;
                prev_db_reg  <= db_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_cur_status_reg <= occ_next;
            m_ext_status_reg <= db_next;
            m_changed_reg    <= changed;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_current_status  = m_cur_status_reg;
    assign m_external_status = m_ext_status_reg;
    assign m_status_changed  = m_changed_reg;

`include "current_occupancy_detector_macros.svh"

    // A scan leaving the input register always lands as a result.
    `COD_ASSERT_NEXT(a_advance_gives_result, advance, m_valid_reg)
    // A scan held in the input register is never dropped.
    `COD_ASSERT_NEXT(a_input_held, in_valid_reg && !advance, in_valid_reg)
    // An empty input register always takes a new item.
    `COD_ASSERT_NOW(a_empty_accepts, !in_valid_reg, s_ready)
    // The change flag agrees with the statuses reported before this result.
    `COD_ASSERT_NEXT(a_change_flag, advance,
        m_changed_reg == (($past(prev_occ_reg) != m_cur_status_reg)
                          || ($past(prev_db_reg) != m_ext_status_reg)))

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import cod_pkg::*;

    // Spare register indexes: writes to them must leave every setting unchanged.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    localparam int REF_SEL_BIT   = THR_W - 1;
    localparam int SAMPLE_MAX    = (1 << SAMPLE_W) - 1;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [NUM_CH-1:0][SAMPLE_W-1:0] current;
        logic [NUM_CH-1:0][SAMPLE_W-1:0] reference;
        logic [EXT_W-1:0]                external_raw;
    } scan_t;

    typedef struct packed {
        logic [NUM_CH-1:0] occupied;
        logic [EXT_W-1:0]  debounced;
        logic              changed;
    } status_t;

    // Scoreboard: keeps its own copy of the settings and the detector state, works out
    // the status of every accepted scan and compares the block's results in order.
    class occupancy_scoreboard;
        logic [THR_W-1:0]      thr_reg [NUM_CH];
        logic [CFG_DATA_W-1:0] on_delays;
        logic [CFG_DATA_W-1:0] off_delays;
        logic [NUM_CH-1:0]     occupied;
        logic [NUM_CH-1:0]     prev_occupied;
        logic [DELAY_W-1:0]    on_cnt [NUM_CH];
        logic [DELAY_W-1:0]    off_cnt [NUM_CH];
        logic [EXT_W-1:0]      deb_lo;
        logic [EXT_W-1:0]      deb_hi;
        logic [EXT_W-1:0]      debounced;
        logic [EXT_W-1:0]      prev_debounced;
        status_t               expected_status_q [$];
        int                    scans_noted;
        int                    statuses_checked;
        int                    changes_seen;
        int                    turn_ons;
        int                    errors;

        function new();
            for (int ch = 0; ch < NUM_CH; ch++) begin
                thr_reg[ch] = THR_RESET;
                on_cnt[ch]  = '0;
                off_cnt[ch] = '0;
            end
            on_delays        = ON_DELAYS_RESET;
            off_delays       = OFF_DELAYS_RESET;
            occupied         = '0;
            prev_occupied    = '0;
            deb_lo           = '0;
            deb_hi           = '0;
            debounced        = '0;
            prev_debounced   = '0;
            scans_noted      = 0;
            statuses_checked = 0;
            changes_seen     = 0;
            turn_ons         = 0;
            errors           = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_THR_CH0, CFG_THR_CH1, CFG_THR_CH2, CFG_THR_CH3: begin
                    thr_reg[idx] = data[THR_W-1:0];
                end
                CFG_ON_DELAYS:  on_delays = data;
                CFG_OFF_DELAYS: off_delays = data;
                // Spare indexes are ignored.
                default: ;
            endcase
        endfunction

        function void add_scan(scan_t sc);
            int               thr;
            bit               was_on;
            logic [DELAY_W-1:0] on_delay;
            logic [DELAY_W-1:0] off_delay;
            logic [EXT_W-1:0] delta;
            logic [EXT_W-1:0] hi;
            logic [EXT_W-1:0] lo;
            status_t          exp;

            // Current channels: threshold with hysteresis, then the delay counters.
            for (int ch = 0; ch < NUM_CH; ch++) begin
                was_on    = occupied[ch];
                on_delay  = on_delays[8*ch +: 8];
                off_delay = off_delays[8*ch +: 8];
                thr = thr_reg[ch][REF_SEL_BIT] ? int'(sc.reference[ch])
                                               : int'(thr_reg[ch][SAMPLE_W-1:0]);
                if (was_on && thr >= int'(HYST)) begin
                    thr -= int'(HYST);
                end else if (!was_on && thr <= int'(HYST_TOP)) begin
                    thr += int'(HYST);
                end
                if (int'(sc.current[ch]) > thr) begin
                    if (!was_on) begin
                        if (on_cnt[ch] < on_delay) begin
                            on_cnt[ch]++;
                        end else begin
                            occupied[ch] = 1'b1;
                            off_cnt[ch]  = '0;
                            turn_ons++;
                        end
                    end else begin
                        off_cnt[ch] = '0;
                    end
                end else begin
                    if (was_on) begin
                        if (off_cnt[ch] < off_delay) begin
                            off_cnt[ch]++;
                        end else begin
                            occupied[ch] = 1'b0;
                            on_cnt[ch]   = '0;
                        end
                    end else begin
                        on_cnt[ch] = '0;
                    end
                end
            end

            // Two-bit vertical counter per external bit; a bit flips when its count wraps.
            delta     = sc.external_raw ^ debounced;
            hi        = (deb_hi ^ deb_lo) & delta;
            lo        = ~deb_lo & delta;
            deb_hi    = hi;
            deb_lo    = lo;
            debounced = debounced ^ (delta & ~(hi | lo));

            exp.changed = 1'b0;
            if (occupied != prev_occupied || debounced != prev_debounced) begin
                prev_occupied  = occupied;
                prev_debounced = debounced;
                exp.changed    = 1'b1;
                changes_seen++;
            end
            exp.occupied  = occupied;
            exp.debounced = debounced;
            expected_status_q.push_back(exp);
            scans_noted++;
        endfunction

        function void check_status(status_t got);
            status_t exp;
            statuses_checked++;
            if (expected_status_q.size() == 0) begin
                $error("result with no scan waiting: current_status %h external_status %h",
                       got.occupied, got.debounced);
                errors++;
                return;
            end
            exp = expected_status_q.pop_front();
            if (got.occupied !== exp.occupied) begin
                $error("current_status: expected %h, actual %h", exp.occupied, got.occupied);
                errors++;
            end
            if (got.debounced !== exp.debounced) begin
                $error("external_status: expected %h, actual %h", exp.debounced, got.debounced);
                errors++;
            end
            if (got.changed !== exp.changed) begin
                $error("status_changed: expected %b, actual %b", exp.changed, got.changed);
                errors++;
            end
        endfunction

        function int outstanding();
            return expected_status_q.size();
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    scan_t                 s_scan    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic [NUM_CH-1:0]     m_current_status;
    logic [EXT_W-1:0]      m_external_status;
    logic                  m_status_changed;

    occupancy_scoreboard   sb;
    int                    send_idle_pct = 0;
    int                    recv_idle_pct = 0;
    int                    stall_cycles  = 0;

    // State of the random scan shaper: each channel holds one side for a run of scans.
    bit                    above [NUM_CH];
    int                    run_left [NUM_CH];
    logic [EXT_W-1:0]      ext_level = '0;

    always #1 aclk = ~aclk;

    current_occupancy_detector u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_current_ch0     (s_scan.current[0]),
        .s_current_ch1     (s_scan.current[1]),
        .s_current_ch2     (s_scan.current[2]),
        .s_current_ch3     (s_scan.current[3]),
        .s_reference_ch0   (s_scan.reference[0]),
        .s_reference_ch1   (s_scan.reference[1]),
        .s_reference_ch2   (s_scan.reference[2]),
        .s_reference_ch3   (s_scan.reference[3]),
        .s_external_raw    (s_scan.external_raw),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_current_status  (m_current_status),
        .m_external_status (m_external_status),
        .m_status_changed  (m_status_changed)
    );

    // Monitor: results are checked before a scan accepted at the same edge is added.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                sb.check_status(status_t'({m_current_status, m_external_status,
                                           m_status_changed}));
            end
            if (cfg_valid && cfg_ready) begin
                sb.write_reg(cfg_index, cfg_data);
            end
            if (s_valid && s_ready) begin
                sb.add_scan(s_scan);
            end
        end
    end

    // Watchdog on cycles in which no channel moves an item.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $error("no item moved for %0d cycles", STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side back-pressure.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_index = idx;
        cfg_data  = data;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Thresholds are written with random upper data bits, which the block must drop.
    task automatic load_setting(input int thr [NUM_CH], input logic [CFG_DATA_W-1:0] on_d,
                                input logic [CFG_DATA_W-1:0] off_d);
        for (int ch = 0; ch < NUM_CH; ch++) begin
            write_register(CFG_THR_CH0 + CFG_IDX_W'(ch),
                           ($urandom() & ~32'h7FF) | (thr[ch] & 32'h7FF));
        end
        write_register(CFG_ON_DELAYS, on_d);
        write_register(CFG_OFF_DELAYS, off_d);
        write_register(CFG_SPARE_6, $urandom());
        write_register(CFG_SPARE_7, $urandom());
    endtask

    task automatic send_scan(input scan_t sc);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_scan  = sc;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Waits until every expected status has arrived, then lets the pipeline settle.
    task automatic wait_idle();
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic scan_t flat_scan(int cur, int refl, logic [EXT_W-1:0] ext);
        scan_t sc;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            sc.current[ch]   = SAMPLE_W'(cur);
            sc.reference[ch] = SAMPLE_W'(refl);
        end
        sc.external_raw = ext;
        return sc;
    endfunction

    // Random scans: each channel sits just above or just below its threshold for runs
    // near its delay count, with some fully random samples mixed in; external bits mostly
    // hold their level for several scans.
    function automatic scan_t next_random_scan();
        scan_t sc;
        int    delay;
        int    level;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            if (run_left[ch] == 0) begin
                above[ch] = 1'($urandom_range(0, 1));
                delay = above[ch] ? int'(sb.on_delays[8*ch +: 8])
                                  : int'(sb.off_delays[8*ch +: 8]);
                run_left[ch] = ($urandom_range(0, 3) == 0)
                             ? delay + 1 + int'($urandom_range(0, 2))
                             : int'($urandom_range(1, delay + 1));
            end
            run_left[ch]--;
            if ($urandom_range(0, 15) == 0) begin
                sc.reference[ch] = $urandom_range(0, 1) ? SAMPLE_W'(SAMPLE_MAX) : '0;
            end else begin
                sc.reference[ch] = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
            end
            if ($urandom_range(0, 9) == 0) begin
                sc.current[ch] = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
            end else begin
                level = sb.thr_reg[ch][REF_SEL_BIT] ? int'(sc.reference[ch])
                                                    : int'(sb.thr_reg[ch][SAMPLE_W-1:0]);
                level += above[ch] ? int'($urandom_range(1, 12)) : -int'($urandom_range(0, 12));
                if (level < 0) begin
                    level = 0;
                end else if (level > SAMPLE_MAX) begin
                    level = SAMPLE_MAX;
                end
                sc.current[ch] = SAMPLE_W'(level);
            end
        end
        if ($urandom_range(0, 15) == 0) begin
            ext_level = EXT_W'($urandom());
        end else begin
            ext_level ^= EXT_W'($urandom() & $urandom() & $urandom());
        end
        sc.external_raw = ext_level;
        return sc;
    endfunction

    initial begin
        scan_t boundary;
        int    random_scans [3];

        random_scans = '{280, 280, 290};
        sb = new();
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        // Reset settings: turn-on after the default delay, external bits settle after four scans.
        send_scan(flat_scan(0, 0, 8'h00));
        repeat (5) send_scan(flat_scan(SAMPLE_MAX, 0, 8'hFF));
        send_scan(flat_scan(SAMPLE_MAX, SAMPLE_MAX, 8'hFF));
        s_valid = 1'b0;
        wait_idle();

        // Zero delays, thresholds at 0 and 1023, and reference selection by 2047 and 1024.
        load_setting('{0, 1023, 2047, 1024}, 32'h0000_0000, 32'h0000_0000);
        repeat (2) send_scan(flat_scan(0, SAMPLE_MAX, 8'h00));
        send_scan(flat_scan(SAMPLE_MAX, 0, 8'hA5));
        send_scan(flat_scan(0, 0, 8'h5A));
        send_scan(flat_scan(SAMPLE_MAX, SAMPLE_MAX, 8'hA5));
        // Samples right on the edges of the hysteresis band.
        boundary              = flat_scan(1019, 0, 8'hA5);
        boundary.current[0]   = 10'd6;
        boundary.reference[2] = 10'd1014;
        boundary.reference[3] = 10'd1013;
        send_scan(boundary);
        repeat (2) send_scan(flat_scan(0, 0, 8'hA5));
        s_valid = 1'b0;
        wait_idle();

        // Random phases, each with its own settings and pacing.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 13;
                    recv_idle_pct = 59;
                    load_setting('{512, 1024, 1018, 1500}, 32'h0302_0100, 32'h0300_02FF);
                end
                1: begin
                    send_idle_pct = 59;
                    recv_idle_pct = 13;
                    load_setting('{$urandom_range(0, SAMPLE_MAX), $urandom_range(1024, 2047),
                                   5, 1019}, 32'hFF00_FF01, 32'h00FF_0302);
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    load_setting('{1023, 0, 1024, $urandom_range(0, 2047)},
                                 32'h02FF_00FF, 32'hFF01_FF00);
                end
            endcase
            repeat (random_scans[phase]) send_scan(next_random_scan());
            s_valid = 1'b0;
            wait_idle();
        end

        $display("Checked %0d statuses for %0d scans: %0d status changes, %0d channel turn-ons.",
                 sb.statuses_checked, sb.scans_noted, sb.changes_seen, sb.turn_ons);
        $display("Settings covered reset values, zero and full delays and reference thresholds.");
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/cod_pkg.sv
hdl/cod_channel.sv
hdl/cod_debounce.sv
hdl/current_occupancy_detector.sv
bench/testbench.sv
